[hdl/quaternion_to_euler_defines.svh]
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH
// implication checked every clock, reset masks it
`define Q2E_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/q2e_pkg.sv]
// Shared constants and helpers for the quaternion to Euler converter.
// No dependencies.
package q2e_pkg;
  localparam int unsigned TabLen = 24;
  localparam int unsigned DatW = 36;  // CORDIC datapath width
  localparam int unsigned IsqW = 62;  // isqrt radicand width

  typedef logic [31:0] ang_t;

  function automatic ang_t atan_tab(input logic [4:0] i);
    ang_t r;
    case (i)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // per-item side data that rides along the pipeline
  // yaw/roll operands reach +-2^32 for non-unit input, hence 34 bits
  typedef struct packed {
    logic        lock;
    logic        s_neg;
    logic [15:0] qy;
    logic [15:0] qw;
    logic [33:0] sy;
    logic [33:0] cy;
    logic [33:0] sz;
    logic [33:0] cz;
  } side_t;
endpackage

[hdl/q2e_isqrt_cell.sv]
// One step of a pipelined integer square root (two radicand bits per cell).
// Depends on q2e_pkg.
module q2e_isqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [q2e_pkg::IsqW-1:0] v_i,
  input  logic [q2e_pkg::IsqW-1:0] r_i,
  output logic [q2e_pkg::IsqW-1:0] v_o,
  output logic [q2e_pkg::IsqW-1:0] r_o
);
  localparam logic [q2e_pkg::IsqW-1:0] Bit =
    q2e_pkg::IsqW'(1) << (q2e_pkg::IsqW - 2 - 2 * Step);
  logic [q2e_pkg::IsqW-1:0] v_d, r_d, v_q, r_q, t;

  always_comb begin
    t = r_i + Bit;
    if (v_i >= t) begin
      v_d = v_i - t;
      r_d = (r_i >> 1) + Bit;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end
  assign v_o = v_q;
  assign r_o = r_q;
endmodule

[hdl/q2e_cordic_cell.sv]
// One vectoring CORDIC micro-rotation on three lanes, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [3*q2e_pkg::DatW-1:0] x_i,
  input  logic signed [3*q2e_pkg::DatW-1:0] y_i,
  input  logic [95:0]                 z_i,
  output logic signed [3*q2e_pkg::DatW-1:0] x_o,
  output logic signed [3*q2e_pkg::DatW-1:0] y_o,
  output logic [95:0]                 z_o
);
  localparam int unsigned W = q2e_pkg::DatW;
  localparam q2e_pkg::ang_t A = q2e_pkg::atan_tab(5'(Idx));
  logic [3*W-1:0] x_d, y_d, x_q, y_q;
  logic [95:0] z_d, z_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [W-1:0] x, y;
      x = x_i[l*W +: W];
      y = y_i[l*W +: W];
      if (!y[W-1]) begin
        x_d[l*W +: W] = x + (y >>> Idx);
        y_d[l*W +: W] = y - (x >>> Idx);
        z_d[l*32 +: 32] = z_i[l*32 +: 32] + A;
      end else begin
        x_d[l*W +: W] = x - (y >>> Idx);
        y_d[l*W +: W] = y + (x >>> Idx);
        z_d[l*32 +: 32] = z_i[l*32 +: 32] - A;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

[hdl/quaternion_to_euler.sv]
// Quaternion (Q1.15) to Euler binary angles. Fully pipelined: one
// transaction per cycle while the output is not held (2 product/sum stages,
// 31 isqrt cells, 1 pre-rotation stage, CORDIC_STAGES cordic cells capped at
// the atan table length, 1 output register). The whole chain stalls when the
// output is held. lock_threshold is sampled per transaction at entry.
module quaternion_to_euler #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        lock_threshold_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic               gimbal_lock_o
);
  localparam int unsigned W = q2e_pkg::DatW;
  localparam int unsigned IW = q2e_pkg::IsqW;
  localparam int unsigned NS = 31;
  localparam int unsigned NC = (CORDIC_STAGES < q2e_pkg::TabLen) ?
                               CORDIC_STAGES : q2e_pkg::TabLen;
  localparam int unsigned Depth = 2 + NS + 1 + NC;

  logic en;
  logic [Depth-1:0] vld_q;
  logic [30:0] thr_q;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 31'd10737;
      vld_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) thr_q <= lock_threshold_i;
      if (en) begin
        vld_q <= {vld_q[Depth-2:0], in_valid_i};
        out_valid_o <= vld_q[Depth-1];
      end
    end
  end

  // stage 1: products
  logic signed [31:0] wx_q, yz_q, wy_q, xz_q, wz_q, xy_q, xx_q, yy_q, zz_q;
  logic [15:0] qy1_q, qw1_q;
  logic [30:0] thr1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i; yz_q <= quat_y_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i; xz_q <= quat_x_i * quat_z_i;
      wz_q <= quat_w_i * quat_z_i; xy_q <= quat_x_i * quat_y_i;
      xx_q <= quat_x_i * quat_x_i; yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      qy1_q <= quat_y_i; qw1_q <= quat_w_i; thr1_q <= thr_q;
    end
  end

  // stage 2: sums, lock test, clamp and radicand
  logic signed [33:0] s, sc;
  logic [32:0] mag, gap;
  logic signed [33:0] sy, cy, sz, cz;
  q2e_pkg::side_t side2_d, side2_q;
  logic signed [31:0] sc2_q;
  logic [IW-1:0] rad;
  logic signed [67:0] scsq;
  always_comb begin
    s = 34'(2) * (34'(wx_q) - 34'(yz_q));
    mag = s[33] ? 33'(-s) : 33'(s);
    gap = (mag >= 33'h4000_0000) ? mag - 33'h4000_0000 : 33'h4000_0000 - mag;
    sc = (s > 34'sh4000_0000) ? 34'sh4000_0000 :
         (s < -34'sh4000_0000) ? -34'sh4000_0000 : s;
    sy = 34'(2) * (34'(wy_q) + 34'(xz_q));
    cy = 34'sh4000_0000 - 34'(2) * (34'(xx_q) + 34'(yy_q));
    sz = 34'(2) * (34'(wz_q) + 34'(xy_q));
    cz = 34'sh4000_0000 - 34'(2) * (34'(xx_q) + 34'(zz_q));
    side2_d.lock = gap < 33'(thr1_q);
    side2_d.s_neg = s[33];
    side2_d.qy = qy1_q;
    side2_d.qw = qw1_q;
    side2_d.sy = sy;
    side2_d.cy = cy;
    side2_d.sz = sz;
    side2_d.cz = cz;
  end
  // square of clamped sine; one multiply, result at most 2^60 in magnitude
  logic signed [31:0] scr_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side2_d;
      scr_q <= sc[31:0];
    end
  end
  assign scsq = 68'(scr_q) * 68'(scr_q);
  assign rad = IW'((64'(1) << 60) - scsq[63:0]);
  assign sc2_q = scr_q;

  // isqrt chain with side data delayed alongside
  logic [IW-1:0] v_ch [NS+1];
  logic [IW-1:0] r_ch [NS+1];
  q2e_pkg::side_t side_ch [NS+1];
  logic signed [31:0] sc_ch [NS+1];
  assign v_ch[0] = rad;
  assign r_ch[0] = '0;
  assign side_ch[0] = side2_q;
  assign sc_ch[0] = sc2_q;
  for (genvar g = 0; g < NS; g++) begin : g_isq
    q2e_isqrt_cell #(.Step(g)) u_cell (
      .clk_i, .en_i(en), .v_i(v_ch[g]), .r_i(r_ch[g]),
      .v_o(v_ch[g+1]), .r_o(r_ch[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_ch[g+1] <= side_ch[g];
        sc_ch[g+1] <= sc_ch[g];
      end
    end
  end

  // pre-rotation into right half plane, three lanes: pitch, yaw, roll
  q2e_pkg::side_t side_p;
  logic signed [W-1:0] ly [3];
  logic signed [W-1:0] lx [3];
  logic [3*W-1:0] x0_d, y0_d;
  logic [95:0] z0_d;
  always_comb begin
    side_p = side_ch[NS];
    if (side_p.lock) begin
      ly[0] = W'($signed(side_p.qy));
      lx[0] = W'($signed(side_p.qw));
    end else begin
      ly[0] = W'(sc_ch[NS]);
      lx[0] = W'($signed({1'b0, r_ch[NS][31:0]}));
    end
    ly[1] = W'($signed(side_p.sy)); lx[1] = W'($signed(side_p.cy));
    ly[2] = W'($signed(side_p.sz)); lx[2] = W'($signed(side_p.cz));
    for (int l = 0; l < 3; l++) begin
      if (lx[l][W-1]) begin
        if (!ly[l][W-1]) begin
          x0_d[l*W +: W] = ly[l]; y0_d[l*W +: W] = -lx[l];
          z0_d[l*32 +: 32] = 32'h4000_0000;
        end else begin
          x0_d[l*W +: W] = -ly[l]; y0_d[l*W +: W] = lx[l];
          z0_d[l*32 +: 32] = 32'hC000_0000;
        end
      end else begin
        x0_d[l*W +: W] = lx[l]; y0_d[l*W +: W] = ly[l];
        z0_d[l*32 +: 32] = '0;
      end
    end
  end
  logic [3*W-1:0] xc [NC+1];
  logic [3*W-1:0] yc [NC+1];
  logic [95:0] zc [NC+1];
  logic [2:0] zero_c [NC+1];
  logic [2:0] zero_d;
  q2e_pkg::side_t side_c [NC+1];
  always_comb begin
    for (int l = 0; l < 3; l++) zero_d[l] = (lx[l] == '0) && (ly[l] == '0);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      xc[0] <= x0_d; yc[0] <= y0_d; zc[0] <= z0_d;
      zero_c[0] <= zero_d; side_c[0] <= side_p;
    end
  end
  for (genvar g = 0; g < NC; g++) begin : g_cor
    q2e_cordic_cell #(.Idx(g)) u_cell (
      .clk_i, .en_i(en), .x_i(xc[g]), .y_i(yc[g]), .z_i(zc[g]),
      .x_o(xc[g+1]), .y_o(yc[g+1]), .z_o(zc[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        zero_c[g+1] <= zero_c[g];
        side_c[g+1] <= side_c[g];
      end
    end
  end

  // output register
  q2e_pkg::ang_t za [3];
  logic [31:0] t0, t1, t2, ty;
  q2e_pkg::side_t so;
  always_comb begin
    so = side_c[NC];
    for (int l = 0; l < 3; l++) za[l] = zero_c[NC][l] ? '0 : zc[NC][l*32 +: 32];
    t0 = za[0] + 32'h8000;
    t1 = za[1] + 32'h8000;
    t2 = za[2] + 32'h8000;
    ty = {za[0][30:0], 1'b0} + 32'h8000;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      gimbal_lock_o <= so.lock;
      if (so.lock) begin
        pitch_angle_o <= so.s_neg ? 16'shC000 : 16'sh4000;
        yaw_angle_o <= ty[31:16];
        roll_angle_o <= '0;
      end else begin
        pitch_angle_o <= t0[31:16];
        yaw_angle_o <= t1[31:16];
        roll_angle_o <= t2[31:16];
      end
    end
  end
endmodule

[hdl/q2e_checker.sv]
// Port-level checker for quaternion_to_euler, bound to the top level.
// Depends on quaternion_to_euler_defines.svh.
`include "quaternion_to_euler_defines.svh"
module q2e_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] pitch_angle_o,
  input logic signed [15:0] roll_angle_o,
  input logic               gimbal_lock_o
);
  `Q2E_ASSERT_IMPL(a_lock_roll, clk_i, rst_ni, out_valid_o && gimbal_lock_o, roll_angle_o == 16'sd0)
  `Q2E_ASSERT_IMPL(a_lock_pitch, clk_i, rst_ni, out_valid_o && gimbal_lock_o, pitch_angle_o == 16'sh4000 || pitch_angle_o == 16'shC000)
  `Q2E_ASSERT_IMPL(a_ready, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)
  `Q2E_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(pitch_angle_o))
endmodule

bind quaternion_to_euler q2e_port_checks u_port_checks (.*);

[bench/q2e_checker.sv]
// Output checker for quaternion_to_euler: predicts Euler binary angles for each
// accepted quaternion and compares them in order. Depends on the block's port set.
`timescale 1ns / 1ps
module q2e_checker #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [30:0]        lock_threshold_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic               gimbal_lock_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 angles_seen_o,
  output int                 locks_seen_o
);
  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic        lock;
  } euler_t;

  localparam longint OneQ30 = 64'sd1 << 30;

  euler_t    angle_queue[$];
  logic [30:0] band_width;

  function automatic logic [31:0] arctan_entry(input int i);
    case (i)
      0: return 32'd536870912;  1: return 32'd316933406;
      2: return 32'd167458907;  3: return 32'd85004756;
      4: return 32'd42667331;   5: return 32'd21354465;
      6: return 32'd10679838;   7: return 32'd5340245;
      8: return 32'd2670163;    9: return 32'd1335087;
      10: return 32'd667544;    11: return 32'd333772;
      12: return 32'd166886;    13: return 32'd83443;
      14: return 32'd41722;     15: return 32'd20861;
      16: return 32'd10430;     17: return 32'd5215;
      18: return 32'd2608;      19: return 32'd1304;
      20: return 32'd652;       21: return 32'd326;
      22: return 32'd163;       default: return 32'd81;
    endcase
  endfunction

  // vectoring rotation, arithmetic shifts are floor shifts
  function automatic logic [31:0] vector_angle(input longint y0, input longint x0);
    longint x, y, t, dx, dy;
    logic [31:0] z;
    x = x0; y = y0; z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 32'h4000_0000;
      end else begin
        t = x; x = -y; y = t; z = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_entry(i);
      end else begin
        x -= dx; y += dy; z -= arctan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] round_angle(input logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h8000;
    return r[31:16];
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic euler_t euler_of(input longint qx, input longint qy, input longint qz,
                                      input longint qw, input logic [30:0] band);
    euler_t e;
    longint s, mag, gap, sc, c;
    s = 2 * (qw * qx - qy * qz);
    mag = s < 0 ? -s : s;
    gap = mag >= OneQ30 ? mag - OneQ30 : OneQ30 - mag;
    if (gap < longint'(band)) begin
      e.pitch = s >= 0 ? 16'h4000 : 16'hC000;
      e.yaw   = round_angle(vector_angle(qy, qw) << 1);
      e.roll  = '0;
      e.lock  = 1'b1;
    end else begin
      sc = s > OneQ30 ? OneQ30 : (s < -OneQ30 ? -OneQ30 : s);
      c = floor_sqrt((64'd1 << 60) - longint'(sc * sc));
      e.pitch = round_angle(vector_angle(sc, c));
      e.yaw   = round_angle(vector_angle(2 * (qw * qy + qx * qz),
                                         OneQ30 - 2 * (qx * qx + qy * qy)));
      e.roll  = round_angle(vector_angle(2 * (qw * qz + qx * qy),
                                         OneQ30 - 2 * (qx * qx + qz * qz)));
      e.lock  = 1'b0;
    end
    return e;
  endfunction

  assign pending_o = angle_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    euler_t want, got;
    if (!rst_ni) begin
      band_width = 31'd10737;
      angle_queue.delete();
      fail_count_o <= 0;
      angles_seen_o <= 0;
      locks_seen_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        angle_queue.push_back(euler_of(quat_x_i, quat_y_i, quat_z_i, quat_w_i, band_width));
      if (cfg_valid_i && cfg_ready_i) band_width = lock_threshold_i;
      if (out_valid_i && out_ready_i) begin
        got = '{pitch_angle_i, yaw_angle_i, roll_angle_i, gimbal_lock_i};
        angles_seen_o <= angles_seen_o + 1;
        if (gimbal_lock_i) locks_seen_o <= locks_seen_o + 1;
        if (angle_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected output transaction");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = angle_queue.pop_front();
          if (want !== got) begin
            if (fail_count_o < 10)
              $display("mismatch: expected p=%0d y=%0d r=%0d l=%0b, got p=%0d y=%0d r=%0d l=%0b",
                       $signed(want.pitch), $signed(want.yaw), $signed(want.roll), want.lock,
                       $signed(got.pitch), $signed(got.yaw), $signed(got.roll), got.lock);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[bench/testbench.sv]
// Top of the quaternion_to_euler bench: clock, reset, stimulus and verdict.
// Depends on the block under test and q2e_checker.
`timescale 1ns / 1ps
module testbench;
  localparam int Drain = 200;
  localparam int Watchdog = 20000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [30:0] lock_threshold_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic signed [15:0] pitch_angle_o, yaw_angle_o, roll_angle_o;
  logic gimbal_lock_o;
  int fail_count, pending, angles_seen, locks_seen;
  int send_idle = 0, recv_stall = 0, idle_cycles = 0, quats_sent = 0;

  always #2 clk_i = ~clk_i;

  quaternion_to_euler uut (.*);

  q2e_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .lock_threshold_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pitch_angle_i(pitch_angle_o), .yaw_angle_i(yaw_angle_o),
    .roll_angle_i(roll_angle_o), .gimbal_lock_i(gimbal_lock_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .angles_seen_o(angles_seen), .locks_seen_o(locks_seen)
  );

  // receiver stall pattern, re-rolled every falling edge
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays up between back-to-back transactions and drops only when idling
  task automatic send_quat(input logic [15:0] x, y, z, w);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_x_i <= x; quat_y_i <= y; quat_z_i <= z; quat_w_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    quats_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic [30:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    lock_threshold_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random quaternion: mostly near-unit, with near-lock and raw noise mixed in
  task automatic send_random();
    real a, b, c, d, n;
    int kind;
    kind = $urandom_range(9);
    if (kind < 2) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      a = $urandom_range(65535) - 32768.0; b = $urandom_range(65535) - 32768.0;
      c = $urandom_range(65535) - 32768.0; d = $urandom_range(65535) - 32768.0;
      if (kind < 4) begin  // near pitch +-90: w = +-x, z = -+y
        c = (kind == 2 ? -b : b); d = (kind == 2 ? a : -a);
        c += $urandom_range(8) - 4.0;
      end
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quat(16'($rtoi(a * 32767.0 / n)), 16'($rtoi(b * 32767.0 / n)),
                16'($rtoi(c * 32767.0 / n)), 16'($rtoi(d * 32767.0 / n)));
    end
  endtask

  initial begin
    logic [30:0] thresholds[6];
    int n;
    thresholds = '{31'd0, 31'd10737, 31'd1, 31'd4000000, 31'h4000_0000, 31'h7FFF_FFFF};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, identity, exact lock, zero vectors, non-unit
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_quat(16'h5A82, 16'h0000, 16'h0000, 16'h5A82);
    send_quat(16'hA57E, 16'h0000, 16'h0000, 16'h5A82);
    send_quat(16'h4000, 16'h4000, 16'hC000, 16'h4000);
    send_quat(16'h4000, 16'hC000, 16'h4000, 16'h4000);
    send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_quat(16'h0000, 16'h8000, 16'h0000, 16'h8000);
    set_threshold(31'h7FFF_FFFF);  // zero sine falls into the band
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h1234, 16'hF000, 16'h0100, 16'h7000);
    // random phases over thresholds and idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      set_threshold(thresholds[ph % 6]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 82; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 82; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      n = (ph % 4 == 0) ? 90 : 50;
      repeat (n) send_random();
    end
    in_valid_i <= 1'b0;
    send_idle = 0; recv_stall = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
    $display("sent %0d quaternions over 6 lock thresholds and 4 idling patterns", quats_sent);
    $display("checked %0d outputs, %0d at gimbal lock", angles_seen, locks_seen);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
